@@ src/biou_pkg.sv @@
// biou_pkg: shared types for the box IoU pipeline.
// No dependencies; imported by biou_area, biou_div_cell and box_iou_unit.
package biou_pkg;

    // Per-request status that rides alongside the divider data.
    typedef struct packed {
        logic empty;    // intersection area is zero
        logic hit;      // non-empty intersection equals one box's area
    } biou_flags_t;

endpackage

@@ src/biou_span.sv @@
// biou_span: first pipeline stage, overlap length of the two boxes on each axis.
// No package dependencies; feeds biou_area.
module biou_span #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] a_left,
    input  logic [COORD_BITS-1:0] a_top,
    input  logic [COORD_BITS-1:0] a_width,
    input  logic [COORD_BITS-1:0] a_height,
    input  logic [COORD_BITS-1:0] b_left,
    input  logic [COORD_BITS-1:0] b_top,
    input  logic [COORD_BITS-1:0] b_width,
    input  logic [COORD_BITS-1:0] b_height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] ov_w,
    output logic [COORD_BITS-1:0] ov_h,
    output logic [COORD_BITS-1:0] aw,
    output logic [COORD_BITS-1:0] ah,
    output logic [COORD_BITS-1:0] bw,
    output logic [COORD_BITS-1:0] bh
);

    logic                  valid_reg;
    logic [COORD_BITS-1:0] ov_w_reg, ov_w_next;
    logic [COORD_BITS-1:0] ov_h_reg, ov_h_next;
    logic [COORD_BITS-1:0] aw_reg, ah_reg, bw_reg, bh_reg;

    function automatic logic [COORD_BITS-1:0] overlap(
        input logic [COORD_BITS-1:0] lo1,
        input logic [COORD_BITS-1:0] len1,
        input logic [COORD_BITS-1:0] lo2,
        input logic [COORD_BITS-1:0] len2
    );
        logic [COORD_BITS:0]   hi1;
        logic [COORD_BITS:0]   hi2;
        logic [COORD_BITS:0]   lo;
        logic [COORD_BITS:0]   hi;
        logic [COORD_BITS:0]   diff;
        hi1  = {1'b0, lo1} + {1'b0, len1};
        hi2  = {1'b0, lo2} + {1'b0, len2};
        lo   = (lo1 > lo2) ? {1'b0, lo1} : {1'b0, lo2};
        hi   = (hi1 < hi2) ? hi1 : hi2;
        diff = hi - lo;
        // overlap never exceeds the shorter length, so the top bit is spare
        return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ov_w_next = overlap(a_left, a_width, b_left, b_width);
        ov_h_next = overlap(a_top, a_height, b_top, b_height);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            ov_w_reg <= ov_w_next;
            ov_h_reg <= ov_h_next;
            aw_reg   <= a_width;
            ah_reg   <= a_height;
            bw_reg   <= b_width;
            bh_reg   <= b_height;
        end
    end

    assign out_valid = valid_reg;
    assign ov_w      = ov_w_reg;
    assign ov_h      = ov_h_reg;
    assign aw        = aw_reg;
    assign ah        = ah_reg;
    assign bw        = bw_reg;
    assign bh        = bh_reg;

endmodule

@@ src/biou_area.sv @@
// biou_area: product stage (three areas) and setup stage (union, flags).
// Depends on biou_pkg; feeds the first biou_div_cell.
module biou_area #(
    parameter int COORD_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS-1:0]     ov_w,
    input  logic [COORD_BITS-1:0]     ov_h,
    input  logic [COORD_BITS-1:0]     aw,
    input  logic [COORD_BITS-1:0]     ah,
    input  logic [COORD_BITS-1:0]     bw,
    input  logic [COORD_BITS-1:0]     bh,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS:0]     inter,
    output logic [2*COORD_BITS:0]     union_area,
    output biou_pkg::biou_flags_t     flags
);
    import biou_pkg::*;

    localparam int AREA_BITS = 2 * COORD_BITS;

    // product stage
    logic                 p_valid_reg;
    logic                 p_ready;
    logic [AREA_BITS-1:0] p_inter_reg, p_inter_next;
    logic [AREA_BITS-1:0] p_area_a_reg, p_area_a_next;
    logic [AREA_BITS-1:0] p_area_b_reg, p_area_b_next;

    // setup stage
    logic                 s_valid_reg;
    logic                 s_ready;
    logic [AREA_BITS:0]   s_inter_reg;
    logic [AREA_BITS:0]   s_union_reg, s_union_next;
    biou_flags_t          s_flags_reg, s_flags_next;

    assign s_ready  = !s_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign in_ready = p_ready;

    always_comb begin
        p_inter_next  = {{COORD_BITS{1'b0}}, ov_w} * {{COORD_BITS{1'b0}}, ov_h};
        p_area_a_next = {{COORD_BITS{1'b0}}, aw} * {{COORD_BITS{1'b0}}, ah};
        p_area_b_next = {{COORD_BITS{1'b0}}, bw} * {{COORD_BITS{1'b0}}, bh};
    end

    always_comb begin
        // a + b - i cannot go negative: i is at most the smaller area
        s_union_next = {1'b0, p_area_a_reg} + {1'b0, p_area_b_reg}
                     - {1'b0, p_inter_reg};
        s_flags_next.empty = (p_inter_reg == '0);
        s_flags_next.hit   = (p_inter_reg != '0)
                          && ((p_inter_reg == p_area_a_reg) || (p_inter_reg == p_area_b_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= in_valid;
            end
            if (s_ready) begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready) begin
            p_inter_reg  <= p_inter_next;
            p_area_a_reg <= p_area_a_next;
            p_area_b_reg <= p_area_b_next;
        end
        if (s_ready) begin
            s_inter_reg <= {1'b0, p_inter_reg};
            s_union_reg <= s_union_next;
            s_flags_reg <= s_flags_next;
        end
    end

    assign out_valid  = s_valid_reg;
    assign inter      = s_inter_reg;
    assign union_area = s_union_reg;
    assign flags      = s_flags_reg;

endmodule

@@ src/biou_div_cell.sv @@
// biou_div_cell: one restoring-division step, one quotient bit per cell.
// Depends on biou_pkg; chained in box_iou_unit.
module biou_div_cell #(
    parameter int REM_BITS = 25,
    parameter int QUO_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REM_BITS-1:0]   in_rem,
    input  logic [REM_BITS-1:0]   in_div,
    input  logic [QUO_BITS-1:0]   in_quo,
    input  biou_pkg::biou_flags_t in_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [REM_BITS-1:0]   out_rem,
    output logic [REM_BITS-1:0]   out_div,
    output logic [QUO_BITS-1:0]   out_quo,
    output biou_pkg::biou_flags_t out_flags
);
    import biou_pkg::*;

    logic                valid_reg;
    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic [REM_BITS-1:0] div_reg;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    biou_flags_t         flags_reg;
    logic [REM_BITS:0]   rem2;
    logic [REM_BITS:0]   diff;
    logic                take;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rem2     = {in_rem, 1'b0};
        diff     = rem2 - {1'b0, in_div};
        take     = (rem2 >= {1'b0, in_div});
        // remainder stays below the divisor, so the top bit drops cleanly
        rem_next = take ? diff[REM_BITS-1:0] : rem2[REM_BITS-1:0];
        quo_next = {in_quo[QUO_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg   <= rem_next;
            div_reg   <= in_div;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

@@ src/box_iou_unit.sv @@
// box_iou_unit: top level, IoU of two axis-aligned boxes, or 1.0 when one is nested.
// Depends on biou_pkg, biou_span, biou_area and biou_div_cell.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_box_{a,b}_{left,top,width,height}
//   m_        out        m_valid / m_ready   m_overlap_ratio, m_containment_hit
//
// Accepts one request per cycle while m_ready keeps the output draining. The
// stages are one span stage, a product stage, a setup stage, FRAC_BITS divider
// cells (one quotient bit each) and the output register.
// aresetn is synchronous and clears only the valid bits of each stage.
// Every stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up under output stall and input
// requests keep coming in until the whole chain is full.
module box_iou_unit #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_box_a_left,
    input  logic [COORD_BITS-1:0] s_box_a_top,
    input  logic [COORD_BITS-1:0] s_box_a_width,
    input  logic [COORD_BITS-1:0] s_box_a_height,
    input  logic [COORD_BITS-1:0] s_box_b_left,
    input  logic [COORD_BITS-1:0] s_box_b_top,
    input  logic [COORD_BITS-1:0] s_box_b_width,
    input  logic [COORD_BITS-1:0] s_box_b_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAC_BITS:0]    m_overlap_ratio,
    output logic                  m_containment_hit
);
    import biou_pkg::*;

    // union and remainder width: a + b needs one bit over a single area
    localparam int REM_BITS = 2 * COORD_BITS + 1;

    // span stage -> area stages
    logic                  sp_valid, sp_ready;
    logic [COORD_BITS-1:0] sp_ov_w, sp_ov_h, sp_aw, sp_ah, sp_bw, sp_bh;

    // divider chain: index 0 is the setup stage output, index FRAC_BITS the last cell
    logic                  c_valid [FRAC_BITS+1];
    logic                  c_ready [FRAC_BITS+1];
    logic [REM_BITS-1:0]   c_rem   [FRAC_BITS+1];
    logic [REM_BITS-1:0]   c_div   [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]  c_quo   [FRAC_BITS+1];
    biou_flags_t           c_flags [FRAC_BITS+1];

    // output register
    logic                  out_valid_reg;
    logic [FRAC_BITS:0]    ratio_reg, ratio_next;
    logic                  hit_reg;
    biou_flags_t           last_flags;

    biou_span #(
        .COORD_BITS(COORD_BITS)
    ) u_span (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .a_left    (s_box_a_left),
        .a_top     (s_box_a_top),
        .a_width   (s_box_a_width),
        .a_height  (s_box_a_height),
        .b_left    (s_box_b_left),
        .b_top     (s_box_b_top),
        .b_width   (s_box_b_width),
        .b_height  (s_box_b_height),
        .out_valid (sp_valid),
        .out_ready (sp_ready),
        .ov_w      (sp_ov_w),
        .ov_h      (sp_ov_h),
        .aw        (sp_aw),
        .ah        (sp_ah),
        .bw        (sp_bw),
        .bh        (sp_bh)
    );

    // The intersection enters the divider as the starting remainder: the
    // numerator is inter << FRAC_BITS, so each cell shifts in one zero bit.
    biou_area #(
        .COORD_BITS(COORD_BITS)
    ) u_area (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sp_valid),
        .in_ready   (sp_ready),
        .ov_w       (sp_ov_w),
        .ov_h       (sp_ov_h),
        .aw         (sp_aw),
        .ah         (sp_ah),
        .bw         (sp_bw),
        .bh         (sp_bh),
        .out_valid  (c_valid[0]),
        .out_ready  (c_ready[0]),
        .inter      (c_rem[0]),
        .union_area (c_div[0]),
        .flags      (c_flags[0])
    );

    assign c_quo[0] = '0;

    // One cell per quotient bit, MSB first. For a partial overlap the
    // intersection is below the union, so the quotient fits FRAC_BITS bits.
    // Empty and contained requests run through as well; their quotient is
    // ignored at the end.
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
        biou_div_cell #(
            .REM_BITS(REM_BITS),
            .QUO_BITS(FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_rem    (c_rem[k]),
            .in_div    (c_div[k]),
            .in_quo    (c_quo[k]),
            .in_flags  (c_flags[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_div   (c_div[k+1]),
            .out_quo   (c_quo[k+1]),
            .out_flags (c_flags[k+1])
        );
    end

    // Advance into the output register when it is empty or being drained.
    assign c_ready[FRAC_BITS] = !out_valid_reg || m_ready;
    assign last_flags         = c_flags[FRAC_BITS];

    always_comb begin
        if (last_flags.empty) begin
            ratio_next = '0;
        end else if (last_flags.hit) begin
            // exactly 1.0
            ratio_next = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            ratio_next = {1'b0, c_quo[FRAC_BITS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (c_ready[FRAC_BITS]) begin
            out_valid_reg <= c_valid[FRAC_BITS];
        end
    end

    // Hold the result while the consumer stalls; load a new one otherwise.
    always_ff @(posedge aclk) begin
        if (c_ready[FRAC_BITS]) begin
            ratio_reg <= ratio_next;
            hit_reg   <= last_flags.hit;
        end
    end

    // c_rem and c_div at the chain end are not needed past the last cell.
    assign m_valid           = out_valid_reg;
    assign m_overlap_ratio   = ratio_reg;
    assign m_containment_hit = hit_reg;

endmodule
